@@ sv/fat_directory_entry_scanner_top_defines.svh @@
// Assertion macros shared by the directory entry scanner RTL.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef FAT_DIRECTORY_ENTRY_SCANNER_TOP_DEFINES_SVH
`define FAT_DIRECTORY_ENTRY_SCANNER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define FDES_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset
`define FDES_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ sv/fdes_pkg.sv @@
// Shared types and constants for the FAT32 directory entry scanner.
// No dependencies; imported by fdes_entry_collect and the top level.
package fdes_pkg;

  // Width of the internal listed-entry counter
  localparam int COUNT_BITS = 16;

  // FAT directory constants
  localparam logic [7:0] LEAD_END      = 8'h00;
  localparam logic [7:0] LEAD_DELETED  = 8'hE5;
  localparam logic [7:0] ATTR_LONGNAME = 8'h0F;
  localparam logic [7:0] ATTR_VOLUME   = 8'h08;
  localparam logic [7:0] ATTR_DIR      = 8'h10;
  localparam int         ENTRY_BYTES   = 32;
  localparam int         OFF_BITS      = $clog2(ENTRY_BYTES);

  // Byte offsets inside a short entry
  localparam logic [OFF_BITS-1:0] OFF_EXT_FIRST = OFF_BITS'(8);
  localparam logic [OFF_BITS-1:0] OFF_ATTR      = OFF_BITS'(11);
  localparam logic [OFF_BITS-1:0] OFF_CLU_HI_LO = OFF_BITS'(20);
  localparam logic [OFF_BITS-1:0] OFF_CLU_HI_HI = OFF_BITS'(21);
  localparam logic [OFF_BITS-1:0] OFF_CLU_LO_LO = OFF_BITS'(26);
  localparam logic [OFF_BITS-1:0] OFF_CLU_LO_HI = OFF_BITS'(27);
  localparam logic [OFF_BITS-1:0] OFF_SIZE_0    = OFF_BITS'(28);
  localparam logic [OFF_BITS-1:0] OFF_SIZE_1    = OFF_BITS'(29);
  localparam logic [OFF_BITS-1:0] OFF_SIZE_2    = OFF_BITS'(30);
  localparam logic [OFF_BITS-1:0] OFF_LAST      = OFF_BITS'(ENTRY_BYTES - 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TARGET_BASE = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_TARGET_EXT  = cfg_idx_t'(1);

  // Reset values of the target name: all spaces
  localparam logic [63:0] TARGET_BASE_RST = 64'h2020_2020_2020_2020;
  localparam logic [23:0] TARGET_EXT_RST  = 24'h20_2020;

  // Entry classification
  typedef enum logic [1:0] {
    KIND_SKIP  = 2'd0,
    KIND_LIST  = 2'd1,
    KIND_MATCH = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_scan;
  } in_item_t;

  typedef struct packed {
    kind_t       entry_kind;
    logic        is_directory;
    logic [31:0] first_cluster;
    logic [31:0] file_size;
    logic [63:0] name_base;
    logic [23:0] name_ext;
    logic [15:0] listed_count;
  } out_item_t;

endpackage

@@ sv/fat_directory_entry_scanner_top.sv @@
// Top level of the FAT32 short directory entry scanner.
// Depends on fdes_pkg, fdes_entry_collect and the assertion macro header.
// Usage:
//   Input channel (in_valid/in_stall/in_item) carries one directory byte per
//   transaction; start_scan = 1 makes that byte offset 0 of a new entry and
//   clears the listed count and the end-of-directory flag.
//   Output channel (out_valid/out_stall/out_item) carries one transaction per
//   completed 32-byte entry: kind, directory flag, first cluster, size, raw
//   name and saturating listed count. Bytes after an end entry give nothing.
//   Configuration: cfg_we writes cfg_wdata into the target base name
//   (index 0) or target extension (index 1); other indexes are ignored.
// Timing:
//   One byte is taken per cycle unless out_stall holds a waiting result. A byte
//   is registered in the input register, then the collector logic updates
//   entry state and, for the 32nd byte of an entry, loads the result register.
//   Unstalled, one byte per cycle passes the single input register stage.
// Reset and stall:
//   Synchronous reset clears the entry state and count and loads spaces into
//   the target name. While a result waits under out_stall, at most one more byte
//   is taken into the input register; in_stall then rises until the result goes.
`include "fat_directory_entry_scanner_top_defines.svh"

module fat_directory_entry_scanner_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fdes_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output fdes_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  fdes_pkg::cfg_idx_t  cfg_index,
  input  logic [63:0]         cfg_wdata
);
  import fdes_pkg::*;

  logic [63:0] target_base_r;
  logic [23:0] target_ext_r;
  logic        s1_valid_r, s1_valid_nxt;
  in_item_t    s1_item_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r;

  logic        blocked;
  logic        advance;
  logic        accept;
  logic        res_valid;
  out_item_t   res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_base_r <= TARGET_BASE_RST;
      target_ext_r  <= TARGET_EXT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_BASE: target_base_r <= cfg_wdata;
        CFG_TARGET_EXT:  target_ext_r  <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input register advances whenever the result register can take
  assign blocked  = out_valid_r && out_stall;
  assign advance  = s1_valid_r && !blocked;
  assign in_stall = s1_valid_r && blocked;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
  end

  fdes_entry_collect u_collect (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .item        (s1_item_r),
    .target_base (target_base_r),
    .target_ext  (target_ext_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks
  `FDES_ASSERT_IMPLY(a_stall_only_when_full, in_stall, s1_valid_r && out_valid_r)
  `FDES_ASSERT_NEXT(a_hold_byte_when_blocked, s1_valid_r && blocked, s1_valid_r)
  `FDES_ASSERT_IMPLY(a_end_fields_zero, out_valid_r && out_item_r.entry_kind == KIND_END,
                     out_item_r.first_cluster == 32'd0 && out_item_r.file_size == 32'd0)

endmodule

@@ sv/fdes_entry_collect.sv @@
// Per-byte entry collector: gathers one 32-byte short entry and classifies it.
// Depends on fdes_pkg for types and constants.
module fdes_entry_collect (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  fdes_pkg::in_item_t  item,
  input  logic [63:0]         target_base,
  input  logic [23:0]         target_ext,
  output logic                res_valid,
  output fdes_pkg::out_item_t res
);
  import fdes_pkg::*;

  logic [OFF_BITS-1:0]   offset_r, offset_nxt;
  logic                  name_eq_r, name_eq_nxt;
  logic [7:0]            lead_r, lead_nxt;
  logic [7:0]            attr_r, attr_nxt;
  logic [15:0]           clu_hi_r, clu_hi_nxt;
  logic [15:0]           clu_lo_r, clu_lo_nxt;
  logic [31:0]           size_r, size_nxt;
  logic [63:0]           base_r, base_nxt;
  logic [23:0]           ext_r, ext_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt;
  logic                  ended_r, ended_nxt;

  logic [7:0]            b;
  logic [OFF_BITS-1:0]   off;
  logic [7:0]            tbyte;
  logic [31:0]           total_ext;
  kind_t                 kind;

  // Next state and result for one accepted byte
  always_comb begin
    offset_nxt  = offset_r;
    name_eq_nxt = name_eq_r;
    lead_nxt    = lead_r;
    attr_nxt    = attr_r;
    clu_hi_nxt  = clu_hi_r;
    clu_lo_nxt  = clu_lo_r;
    size_nxt    = size_r;
    base_nxt    = base_r;
    ext_nxt     = ext_r;
    total_nxt   = total_r;
    ended_nxt   = ended_r;
    res_valid   = 1'b0;
    res         = '0;
    kind        = KIND_SKIP;
    b           = item.data_byte;
    off         = '0;
    tbyte       = '0;
    total_ext   = '0;

    if (step_en) begin
      // Restart: new entry, clear count and end flag
      if (item.start_scan) begin
        offset_nxt = '0;
        total_nxt  = '0;
        ended_nxt  = 1'b0;
      end
      off = offset_nxt;

      if (!ended_nxt) begin
        // Collect the field that this byte belongs to
        if (off < OFF_EXT_FIRST) begin
          tbyte = target_base[{~off[2:0], 3'b000} +: 8];
          if (off == '0) begin
            base_nxt    = {56'd0, b};
            name_eq_nxt = (b == tbyte);
            lead_nxt    = b;
          end else begin
            base_nxt    = {base_r[55:0], b};
            name_eq_nxt = name_eq_r && (b == tbyte);
          end
        end else if (off < OFF_ATTR) begin
          case (off[1:0])
            2'd0:    tbyte = target_ext[23:16];
            2'd1:    tbyte = target_ext[15:8];
            default: tbyte = target_ext[7:0];
          endcase
          if (off == OFF_EXT_FIRST) begin
            ext_nxt = {16'd0, b};
          end else begin
            ext_nxt = {ext_r[15:0], b};
          end
          name_eq_nxt = name_eq_r && (b == tbyte);
        end else if (off == OFF_ATTR) begin
          attr_nxt = b;
        end else if (off == OFF_CLU_HI_LO) begin
          clu_hi_nxt = {clu_hi_r[15:8], b};
        end else if (off == OFF_CLU_HI_HI) begin
          clu_hi_nxt = {b, clu_hi_r[7:0]};
        end else if (off == OFF_CLU_LO_LO) begin
          clu_lo_nxt = {clu_lo_r[15:8], b};
        end else if (off == OFF_CLU_LO_HI) begin
          clu_lo_nxt = {b, clu_lo_r[7:0]};
        end else if (off == OFF_SIZE_0) begin
          size_nxt = {24'd0, b};
        end else if (off == OFF_SIZE_1) begin
          size_nxt = size_r | {16'd0, b, 8'd0};
        end else if (off == OFF_SIZE_2) begin
          size_nxt = size_r | {8'd0, b, 16'd0};
        end else if (off == OFF_LAST) begin
          size_nxt = size_r | {b, 24'd0};
        end

        offset_nxt = off + OFF_BITS'(1);

        // Classify on the last byte of the entry
        if (off == OFF_LAST) begin
          if (lead_nxt == LEAD_END) begin
            kind      = KIND_END;
            ended_nxt = 1'b1;
          end else if (lead_nxt == LEAD_DELETED || attr_nxt == ATTR_LONGNAME ||
                       (attr_nxt & ATTR_VOLUME) != 8'd0) begin
            kind = KIND_SKIP;
          end else begin
            kind = name_eq_nxt ? KIND_MATCH : KIND_LIST;
            if (total_nxt != '1) begin
              total_nxt = total_nxt + COUNT_BITS'(1);
            end
          end

          total_ext        = 32'(total_nxt);
          res_valid        = 1'b1;
          res.entry_kind   = kind;
          res.listed_count = (total_ext > 32'h0000_FFFF) ? 16'hFFFF : total_ext[15:0];
          if (kind != KIND_END) begin
            res.is_directory  = (attr_nxt & ATTR_DIR) != 8'd0;
            res.first_cluster = {clu_hi_nxt, clu_lo_nxt};
            res.file_size     = size_nxt;
            res.name_base     = base_nxt;
            res.name_ext      = ext_nxt;
          end
        end
      end
    end
  end

  // Hold entry state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= '0;
      name_eq_r <= 1'b1;
      lead_r    <= '0;
      attr_r    <= '0;
      clu_hi_r  <= '0;
      clu_lo_r  <= '0;
      size_r    <= '0;
      base_r    <= '0;
      ext_r     <= '0;
      total_r   <= '0;
      ended_r   <= 1'b0;
    end else begin
      offset_r  <= offset_nxt;
      name_eq_r <= name_eq_nxt;
      lead_r    <= lead_nxt;
      attr_r    <= attr_nxt;
      clu_hi_r  <= clu_hi_nxt;
      clu_lo_r  <= clu_lo_nxt;
      size_r    <= size_nxt;
      base_r    <= base_nxt;
      ext_r     <= ext_nxt;
      total_r   <= total_nxt;
      ended_r   <= ended_nxt;
    end
  end

endmodule
